/* rtl/oqn_pkg.sv */
// ----------------------------------------------------------------------------
// oqn_pkg: shared types, constants and width helpers
// Holds the widths of the fixed output fields, the scale register reset value,
// the per-item control bundle and the derived datapath widths.
// ----------------------------------------------------------------------------
package oqn_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int QW             = 16;   // bits resolved by the cell chain
    localparam int OUT_W          = 16;
    localparam int SCALE_W        = 15;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd4096;
    localparam int FRONT_STAGES   = 7;

    // Control that travels with one item down the pipeline.
    typedef struct packed {
        logic       valid;
        logic       deg;
        logic [2:0] neg;
    } t_ctl;

    // Unsigned magnitude of a cross product component.
    function automatic int f_nw(input int c);
        return 2 * c + 2;
    endfunction

    // Squared length of the cross product.
    function automatic int f_sw(input int c);
        return 4 * c + 4;
    endfunction

    // Magnitude times scale.
    function automatic int f_mw(input int c);
        return 2 * c + 2 + SCALE_W;
    endfunction

    // Square of magnitude times scale: the radicand target.
    function automatic int f_tw(input int c);
        return 2 * f_mw(c);
    endfunction

    // Running product q * S.
    function automatic int f_pw(input int c);
        return f_sw(c) + QW;
    endfunction

    // Working width of the trial subtraction in a cell.
    function automatic int f_xw(input int c);
        return 4 * c + 38;
    endfunction

endpackage

/* rtl/oqn_front.sv */
// ----------------------------------------------------------------------------
// oqn_front: cross product and setup pipeline
// Seven stages form the edges, the exact cross product, the outward test,
// the squared length S and the per-component targets (|n_i| * scale)^2.
// ----------------------------------------------------------------------------
module oqn_front
    import oqn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [SCALE_W-1:0]           i_scale,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    input  logic signed [COORD_BITS-1:0] i_d_x,
    input  logic signed [COORD_BITS-1:0] i_d_y,
    input  logic signed [COORD_BITS-1:0] i_d_z,
    output t_ctl                         o_ctl,
    output logic [f_sw(COORD_BITS)-1:0]  o_s,
    output logic [2:0][f_tw(COORD_BITS)-1:0] o_t
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 1;
    localparam int SMW = C + 2;
    localparam int PRW = 2 * C + 2;
    localparam int NSW = 2 * C + 3;
    localparam int NW  = f_nw(C);
    localparam int SW  = f_sw(C);
    localparam int MW  = f_mw(C);
    localparam int TW  = f_tw(C);
    localparam int OW  = NW + SMW;
    localparam int NL  = NW / 2;
    localparam int NH  = NW - NL;
    localparam int ML  = MW / 2;
    localparam int MH  = MW - ML;

    // Stage 1: edges and coordinate sums.
    logic                  r_v1;
    logic signed [EW-1:0]  r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [SMW-1:0] r_sx1, r_sz1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
        r_e1x <= EW'(i_b_x) - EW'(i_a_x);
        r_e1y <= EW'(i_b_y) - EW'(i_a_y);
        r_e1z <= EW'(i_b_z) - EW'(i_a_z);
        r_e2x <= EW'(i_d_x) - EW'(i_a_x);
        r_e2y <= EW'(i_d_y) - EW'(i_a_y);
        r_e2z <= EW'(i_d_z) - EW'(i_a_z);
        r_sx1 <= SMW'(i_a_x) + SMW'(i_b_x) + SMW'(i_c_x) + SMW'(i_d_x);
        r_sz1 <= SMW'(i_a_z) + SMW'(i_b_z) + SMW'(i_c_z) + SMW'(i_d_z);
    end

    // Stage 2: the edge products that form each cross product component.
    logic                  r_v2;
    logic signed [PRW-1:0] r_pr [6];
    logic signed [SMW-1:0] r_sx2, r_sz2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_pr[0] <= PRW'(r_e1y) * PRW'(r_e2z);
        r_pr[1] <= PRW'(r_e1z) * PRW'(r_e2y);
        r_pr[2] <= PRW'(r_e1z) * PRW'(r_e2x);
        r_pr[3] <= PRW'(r_e1x) * PRW'(r_e2z);
        r_pr[4] <= PRW'(r_e1x) * PRW'(r_e2y);
        r_pr[5] <= PRW'(r_e1y) * PRW'(r_e2x);
        r_sx2   <= r_sx1;
        r_sz2   <= r_sz1;
    end

    // Stage 3: cross product components.
    logic                  r_v3;
    logic signed [NSW-1:0] r_n [3];
    logic signed [SMW-1:0] r_sx3, r_sz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int k = 0; k < 3; k++) begin
            r_n[k] <= NSW'(r_pr[2*k]) - NSW'(r_pr[2*k+1]);
        end
        r_sx3 <= r_sx2;
        r_sz3 <= r_sz2;
    end

    // Stage 4: magnitudes and signs.
    logic                  r_v4, r_deg4, r_sxn4, r_szn4;
    logic [NW-1:0]         r_m4 [3];
    logic [2:0]            r_nn4;
    logic [SMW-1:0]        r_sxm4, r_szm4;
    logic signed [NSW-1:0] n_abs [3];
    logic signed [SMW-1:0] n_sxa, n_sza;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_abs[k] = r_n[k][NSW-1] ? -r_n[k] : r_n[k];
        end
        n_sxa = r_sx3[SMW-1] ? -r_sx3 : r_sx3;
        n_sza = r_sz3[SMW-1] ? -r_sz3 : r_sz3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        for (int k = 0; k < 3; k++) begin
            r_m4[k]  <= n_abs[k][NW-1:0];
            r_nn4[k] <= r_n[k][NSW-1];
        end
        r_deg4 <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        r_sxm4 <= n_sxa;
        r_szm4 <= n_sza;
        r_sxn4 <= r_sx3[SMW-1];
        r_szn4 <= r_sz3[SMW-1];
    end

    // Stage 5: scaled magnitudes, outward products, square partials.
    logic              r_v5, r_deg5, r_on0, r_on2;
    logic [2:0]        r_nn5;
    logic [MW-1:0]     r_p5 [3];
    logic [OW-1:0]     r_o0, r_o2;
    logic [2*NH-1:0]   r_nhh [3];
    logic [NH+NL-1:0]  r_nhl [3];
    logic [2*NL-1:0]   r_nll [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        for (int k = 0; k < 3; k++) begin
            r_p5[k]  <= MW'(r_m4[k]) * MW'(i_scale);
            r_nhh[k] <= (2*NH)'(r_m4[k][NW-1:NL]) * (2*NH)'(r_m4[k][NW-1:NL]);
            r_nhl[k] <= (NH+NL)'(r_m4[k][NW-1:NL]) * (NH+NL)'(r_m4[k][NL-1:0]);
            r_nll[k] <= (2*NL)'(r_m4[k][NL-1:0]) * (2*NL)'(r_m4[k][NL-1:0]);
        end
        r_o0   <= OW'(r_m4[0]) * OW'(r_sxm4);
        r_o2   <= OW'(r_m4[2]) * OW'(r_szm4);
        r_on0  <= r_nn4[0] ^ r_sxn4;
        r_on2  <= r_nn4[2] ^ r_szn4;
        r_nn5  <= r_nn4;
        r_deg5 <= r_deg4;
    end

    // Stage 6: outward decision, component squares, target square partials.
    logic              r_v6, r_deg6;
    logic [2:0]        r_neg6;
    logic [SW-1:0]     r_sq6 [3];
    logic [2*MH-1:0]   r_phh [3];
    logic [MH+ML-1:0]  r_phl [3];
    logic [2*ML-1:0]   r_pll [3];
    logic [OW:0]       n_pos, n_negs;
    logic              n_flip;

    always_comb begin
        n_pos  = (r_on0 ? '0 : (OW+1)'(r_o0)) + (r_on2 ? '0 : (OW+1)'(r_o2));
        n_negs = (r_on0 ? (OW+1)'(r_o0) : '0) + (r_on2 ? (OW+1)'(r_o2) : '0);
        n_flip = n_negs > n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        for (int k = 0; k < 3; k++) begin
            r_sq6[k] <= (SW'(r_nhh[k]) << (2*NL)) + (SW'(r_nhl[k]) << (NL+1))
                        + SW'(r_nll[k]);
            r_phh[k] <= (2*MH)'(r_p5[k][MW-1:ML]) * (2*MH)'(r_p5[k][MW-1:ML]);
            r_phl[k] <= (MH+ML)'(r_p5[k][MW-1:ML]) * (MH+ML)'(r_p5[k][ML-1:0]);
            r_pll[k] <= (2*ML)'(r_p5[k][ML-1:0]) * (2*ML)'(r_p5[k][ML-1:0]);
        end
        r_neg6 <= r_nn5 ^ {3{n_flip}};
        r_deg6 <= r_deg5;
    end

    // Stage 7: squared length and targets.
    logic                 r_v7, r_deg7;
    logic [2:0]           r_neg7;
    logic [SW-1:0]        r_s7;
    logic [2:0][TW-1:0]   r_t7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else begin
            r_v7 <= r_v6;
        end
        r_s7 <= r_sq6[0] + r_sq6[1] + r_sq6[2];
        for (int k = 0; k < 3; k++) begin
            r_t7[k] <= (TW'(r_phh[k]) << (2*ML)) + (TW'(r_phl[k]) << (ML+1))
                       + TW'(r_pll[k]);
        end
        r_neg7 <= r_neg6;
        r_deg7 <= r_deg6;
    end

    assign o_ctl = '{valid: r_v7, deg: r_deg7, neg: r_neg7};
    assign o_s   = r_s7;
    assign o_t   = r_t7;

endmodule

/* rtl/oqn_cell.sv */
// ----------------------------------------------------------------------------
// oqn_cell: one bit of the scaled square root, for all three components
// Tries bit BIT of q using the remainder R = t - q^2*S and the running
// product P = q*S, then passes the updated state to the next cell.
// ----------------------------------------------------------------------------
module oqn_cell
    import oqn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int BIT        = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_ctl                              i_ctl,
    input  logic [f_sw(COORD_BITS)-1:0]       i_s,
    input  logic [2:0][f_tw(COORD_BITS)-1:0]  i_r,
    input  logic [2:0][f_pw(COORD_BITS)-1:0]  i_p,
    input  logic [2:0][QW-1:0]                i_q,
    output t_ctl                              o_ctl,
    output logic [f_sw(COORD_BITS)-1:0]       o_s,
    output logic [2:0][f_tw(COORD_BITS)-1:0]  o_r,
    output logic [2:0][f_pw(COORD_BITS)-1:0]  o_p,
    output logic [2:0][QW-1:0]                o_q
);

    localparam int TW = f_tw(COORD_BITS);
    localparam int PW = f_pw(COORD_BITS);
    localparam int XW = f_xw(COORD_BITS);

    t_ctl               r_ctl;
    logic [f_sw(COORD_BITS)-1:0] r_s;
    logic [2:0][TW-1:0] r_r, n_r;
    logic [2:0][PW-1:0] r_p, n_p;
    logic [2:0][QW-1:0] r_q, n_q;
    logic [XW-1:0]      n_sub [3];
    logic [2:0]         n_ok;

    // Setting bit BIT grows q^2*S by P*2^(BIT+1) + S*4^BIT.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sub[k] = (XW'(i_p[k]) << (BIT + 1)) + (XW'(i_s) << (2 * BIT));
            n_ok[k]  = XW'(i_r[k]) >= n_sub[k];
            n_r[k]   = n_ok[k] ? TW'(XW'(i_r[k]) - n_sub[k]) : i_r[k];
            n_p[k]   = n_ok[k] ? PW'(XW'(i_p[k]) + (XW'(i_s) << BIT)) : i_p[k];
            n_q[k]   = i_q[k] | (QW'(n_ok[k]) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.deg <= i_ctl.deg;
        r_ctl.neg <= i_ctl.neg;
        r_s       <= i_s;
        r_r       <= n_r;
        r_p       <= n_p;
        r_q       <= n_q;
    end

    assign o_ctl = r_ctl;
    assign o_s   = r_s;
    assign o_r   = r_r;
    assign o_p   = r_p;
    assign o_q   = r_q;

endmodule

/* rtl/outward_quad_normal.sv */
// ----------------------------------------------------------------------------
// outward_quad_normal: scaled outward unit normal of a quad
// Takes quad corners a, b, c and d, forms the exact cross product of edges b-a and
// d-a, turns it away from the vertical axis and scales it to the scale register.
// ----------------------------------------------------------------------------
// Usage: drive the corner coordinates and raise start for one cycle per
// transaction. busy is always low, so a new quad can be accepted in every
// clock cycle and the block sustains one transaction per cycle.
// Each result appears on o_normal_x/y/z and o_degenerate for exactly one
// cycle, marked by o_valid, after passing through seven setup stages (edges,
// cross product, magnitudes, multiplies, outward test, squared length S and
// targets), sixteen square-root cells that each resolve one result bit, and
// one output register. The receiver cannot stall; results simply stream out
// in acceptance order.
// The scale register is written through the config channel, which is
// always ready; write it only while no transaction is in flight.
// Reset is synchronous and active low: it empties the pipeline and sets the
// scale to 4096. A quad whose cross product is zero yields zero components
// with o_degenerate set.
// ----------------------------------------------------------------------------
module outward_quad_normal
    import oqn_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [SCALE_W-1:0]           i_cfg_data,
    input  logic signed [COORD_BITS-1:0] i_a_x,
    input  logic signed [COORD_BITS-1:0] i_a_y,
    input  logic signed [COORD_BITS-1:0] i_a_z,
    input  logic signed [COORD_BITS-1:0] i_b_x,
    input  logic signed [COORD_BITS-1:0] i_b_y,
    input  logic signed [COORD_BITS-1:0] i_b_z,
    input  logic signed [COORD_BITS-1:0] i_c_x,
    input  logic signed [COORD_BITS-1:0] i_c_z,
    input  logic signed [COORD_BITS-1:0] i_d_x,
    input  logic signed [COORD_BITS-1:0] i_d_y,
    input  logic signed [COORD_BITS-1:0] i_d_z,
    output logic                         o_valid,
    output logic signed [OUT_W-1:0]      o_normal_x,
    output logic signed [OUT_W-1:0]      o_normal_y,
    output logic signed [OUT_W-1:0]      o_normal_z,
    output logic                         o_degenerate
);

    localparam int SW = f_sw(COORD_BITS);
    localparam int TW = f_tw(COORD_BITS);
    localparam int PW = f_pw(COORD_BITS);

    // The pipeline never holds off a transaction.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    // Node QW is the front end output; cell b reads node b+1 and drives node b.
    t_ctl               w_ctl [QW+1];
    logic [SW-1:0]      w_s   [QW+1];
    logic [2:0][TW-1:0] w_r   [QW+1];
    logic [2:0][PW-1:0] w_p   [QW+1];
    logic [2:0][QW-1:0] w_q   [QW+1];

    oqn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (start && !busy),
        .i_scale  (r_scale),
        .i_a_x    (i_a_x),
        .i_a_y    (i_a_y),
        .i_a_z    (i_a_z),
        .i_b_x    (i_b_x),
        .i_b_y    (i_b_y),
        .i_b_z    (i_b_z),
        .i_c_x    (i_c_x),
        .i_c_z    (i_c_z),
        .i_d_x    (i_d_x),
        .i_d_y    (i_d_y),
        .i_d_z    (i_d_z),
        .o_ctl    (w_ctl[QW]),
        .o_s      (w_s[QW]),
        .o_t      (w_r[QW])
    );

    // The root search starts with q = 0, so the running product is zero.
    assign w_p[QW] = '0;
    assign w_q[QW] = '0;

    for (genvar b = QW - 1; b >= 0; b--) begin : g_cell
        oqn_cell #(
            .COORD_BITS (COORD_BITS),
            .BIT        (b)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[b+1]),
            .i_s     (w_s[b+1]),
            .i_r     (w_r[b+1]),
            .i_p     (w_p[b+1]),
            .i_q     (w_q[b+1]),
            .o_ctl   (w_ctl[b]),
            .o_s     (w_s[b]),
            .o_r     (w_r[b]),
            .o_p     (w_p[b]),
            .o_q     (w_q[b])
        );
    end

    // Output register: apply the sign, and force zeros for a degenerate quad.
    logic                  r_valid, r_deg;
    logic [2:0][OUT_W-1:0] r_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl[0].valid;
        end
        r_deg <= w_ctl[0].deg;
        for (int k = 0; k < 3; k++) begin
            if (w_ctl[0].deg) begin
                r_nrm[k] <= '0;
            end else if (w_ctl[0].neg[k]) begin
                r_nrm[k] <= OUT_W'(0) - w_q[0][k];
            end else begin
                r_nrm[k] <= w_q[0][k];
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_normal_x   = r_nrm[0];
    assign o_normal_y   = r_nrm[1];
    assign o_normal_z   = r_nrm[2];
    assign o_degenerate = r_deg;

endmodule

/* rtl/oqn_checker.sv */
// ----------------------------------------------------------------------------
// oqn_checker: port level checks for outward_quad_normal
// Checks latency in both directions and the shape of each result.
// ----------------------------------------------------------------------------
module oqn_checker
    import oqn_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic signed [OUT_W-1:0] o_normal_x,
    input logic signed [OUT_W-1:0] o_normal_y,
    input logic signed [OUT_W-1:0] o_normal_z,
    input logic                    o_degenerate
);

    localparam int LAT = FRONT_STAGES + QW + 1;

    // Every accepted transaction produces a result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a matching earlier accepted transaction.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without an accepted transaction");

    // A degenerate quad reports all components as zero.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |->
        (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("degenerate result with nonzero components");

    // Components never reach the most negative code.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x != {1'b1, {(OUT_W-1){1'b0}}} &&
                     o_normal_y != {1'b1, {(OUT_W-1){1'b0}}} &&
                     o_normal_z != {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("normal component out of range");

endmodule

bind outward_quad_normal oqn_checker u_oqn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z),
    .o_degenerate (o_degenerate)
);
